/* sv/tgbg_pkg.sv */
// ----------------------------------------------------------------------------
// tgbg_pkg: shared types and codes for the toroidal grid distance-field block
// Holds command codes, status codes and the request type passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none
package tgbg_pkg;
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_SEED  = 2'd1;
	localparam logic [1:0] OP_RUN   = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [5:0]  pos_x;
		logic [5:0]  pos_y;
		logic [15:0] cell_value;
		logic        in_range;
	} tgbg_req_t;
endpackage
`default_nettype wire

/* sv/tgbg_ram.sv */
// ----------------------------------------------------------------------------
// tgbg_ram: generic single-port RAM with registered read
// One write or one read per cycle; read data appears the cycle after.
// ----------------------------------------------------------------------------
`default_nettype none
module tgbg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

/* sv/tgbg_front.sv */
// ----------------------------------------------------------------------------
// tgbg_front: command intake and classification
// Registers each request with its range check into a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module tgbg_front import tgbg_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic [1:0] opcode,
	input  wire logic [5:0] pos_x,
	input  wire logic [5:0] pos_y,
	input  wire logic [15:0] cell_value,
	input  wire logic      cfg_we,
	input  wire logic      cfg_index,
	input  wire logic [6:0] cfg_data,
	input  wire logic      pop,
	output logic           accept,
	output logic           fifo_valid,
	output tgbg_req_t      fifo_head,
	output logic [8:0]     eff_w,
	output logic [8:0]     eff_h,
	output logic           busy_out
);
	logic [6:0] width_q, height_q;
	tgbg_req_t  ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	tgbg_req_t  req;

	always_comb begin
		if (width_q == 7'd0) eff_w = 9'd1;
		else if ({2'b0, width_q} > 9'(MAX_WIDTH)) eff_w = 9'(MAX_WIDTH);
		else eff_w = {2'b0, width_q};
		if (height_q == 7'd0) eff_h = 9'd1;
		else if ({2'b0, height_q} > 9'(MAX_HEIGHT)) eff_h = 9'(MAX_HEIGHT);
		else eff_h = {2'b0, height_q};
	end

	assign busy_out   = cnt_q[1];
	assign accept     = start && !cnt_q[1];
	assign fifo_valid = cnt_q != 2'd0;
	assign fifo_head  = ent_q[rp_q];

	always_comb begin
		req.opcode     = opcode;
		req.pos_x      = pos_x;
		req.pos_y      = pos_y;
		req.cell_value = cell_value;
		req.in_range   = ({3'b0, pos_x} < eff_w) && ({3'b0, pos_y} < eff_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
			wp_q     <= 1'b0;
			rp_q     <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			if (accept) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(accept) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) ent_q[wp_q] <= req;
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> fifo_valid)
		else $error("pop from empty request queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("request queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("request count lost an entry");
endmodule
`default_nettype wire

/* sv/tgbg_back.sv */
// ----------------------------------------------------------------------------
// tgbg_back: execution engine
// Carries out writes, seeds, reads and the breadth-first run over the grid
// and position queue memories.
// ----------------------------------------------------------------------------
`default_nettype none
module tgbg_back import tgbg_pkg::*; #(
	parameter int MAX_WIDTH   = 64,
	parameter int MAX_HEIGHT  = 64,
	parameter int QUEUE_DEPTH = 8192
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fifo_valid,
	input  tgbg_req_t       fifo_head,
	input  wire logic [8:0] eff_w,
	input  wire logic [8:0] eff_h,
	output logic            pop,
	output logic            done,
	output logic [15:0]     read_value,
	output logic [1:0]      status
);
	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int GA = $clog2(CELLS);
	localparam int QA = $clog2(QUEUE_DEPTH);
	localparam int QC = QA + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RDWAIT = 4'd1;
	localparam logic [3:0] S_RDOUT = 4'd2;
	localparam logic [3:0] S_POP   = 4'd3;
	localparam logic [3:0] S_QWAIT = 4'd4;
	localparam logic [3:0] S_CTR   = 4'd5;
	localparam logic [3:0] S_CWAIT = 4'd6;
	localparam logic [3:0] S_NB    = 4'd7;
	localparam logic [3:0] S_NWAIT = 4'd8;
	localparam logic [3:0] S_NCHK  = 4'd9;

	logic [3:0]    state_q;
	logic [QA-1:0] head_q, tail_q;
	logic [QC-1:0] count_q;
	logic [8:0]    x_q, y_q, nx_q, ny_q;
	logic [3:0]    k_q;
	logic [15:0]   nv_q;

	logic          g_we;
	logic [GA-1:0] g_addr;
	logic [15:0]   g_wdata, g_rdata;
	logic          q_we;
	logic [QA-1:0] q_addr;
	logic [17:0]   q_wdata, q_rdata;

	logic          qfull;
	logic [8:0]    nx, ny, xm, xp, ym, yp;

	assign qfull = count_q >= QC'(QUEUE_DEPTH);

	function automatic logic [GA-1:0] gidx(logic [8:0] x, logic [8:0] y);
		logic [31:0] t;
		t = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
		return GA'(t);
	endfunction

	always_comb begin
		xm = (x_q == 9'd0) ? eff_w - 9'd1 : x_q - 9'd1;
		xp = (x_q + 9'd1 >= eff_w) ? x_q + 9'd1 - eff_w : x_q + 9'd1;
		ym = (y_q == 9'd0) ? eff_h - 9'd1 : y_q - 9'd1;
		yp = (y_q + 9'd1 >= eff_h) ? y_q + 9'd1 - eff_h : y_q + 9'd1;
		case (k_q)
			4'd0, 4'd3, 4'd5: nx = xm;
			4'd2, 4'd4, 4'd7: nx = xp;
			default: nx = x_q;
		endcase
		case (k_q)
			4'd0, 4'd1, 4'd2: ny = ym;
			4'd5, 4'd6, 4'd7: ny = yp;
			default: ny = y_q;
		endcase
	end

	always_comb begin
		g_we = 1'b0;
		g_addr = gidx(9'(fifo_head.pos_x), 9'(fifo_head.pos_y));
		g_wdata = fifo_head.cell_value;
		q_we = 1'b0;
		q_addr = head_q;
		q_wdata = {9'(fifo_head.pos_y), 9'(fifo_head.pos_x)};
		pop = 1'b0;
		done = 1'b0;
		read_value = 16'd0;
		status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (fifo_valid) begin
					unique case (fifo_head.opcode)
						OP_WRITE: begin
							pop = 1'b1; done = 1'b1;
							g_we = fifo_head.in_range;
							status = fifo_head.in_range ? ST_OK : ST_RANGE;
						end
						OP_SEED: begin
							pop = 1'b1; done = 1'b1;
							q_addr = tail_q;
							q_we = fifo_head.in_range && !qfull;
							status = !fifo_head.in_range ? ST_RANGE :
								(qfull ? ST_FULL : ST_OK);
						end
						OP_RUN: begin
							if (count_q == '0) begin
								pop = 1'b1; done = 1'b1;
							end
						end
						OP_READ: begin
							if (!fifo_head.in_range) begin
								pop = 1'b1; done = 1'b1; status = ST_RANGE;
							end
						end
						default: ;
					endcase
				end
			end
			S_RDOUT: begin
				pop = 1'b1; done = 1'b1; read_value = g_rdata;
			end
			S_CTR: g_addr = gidx(x_q, y_q);
			S_NB: g_addr = gidx(nx, ny);
			// Hold the neighbor address so its data is still on the read port.
			S_NWAIT: g_addr = gidx(nx_q, ny_q);
			S_NCHK: begin
				g_addr = gidx(nx_q, ny_q);
				g_wdata = nv_q;
				g_we = g_rdata == 16'd0;
				q_addr = tail_q;
				q_wdata = {ny_q, nx_q};
				q_we = g_we && !qfull;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			k_q     <= '0;
		end else begin
			if (q_we) begin
				tail_q <= (tail_q == QA'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QA'(1);
			end
			count_q <= count_q + QC'(q_we) - QC'(state_q == S_POP);
			if (state_q == S_POP) begin
				head_q <= (head_q == QA'(QUEUE_DEPTH - 1)) ? '0 : head_q + QA'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (fifo_valid && fifo_head.opcode == OP_READ && fifo_head.in_range)
						state_q <= S_RDWAIT;
					else if (fifo_valid && fifo_head.opcode == OP_RUN && count_q != '0)
						state_q <= S_POP;
				end
				S_RDWAIT: state_q <= S_RDOUT;
				S_RDOUT:  state_q <= S_IDLE;
				S_POP:    state_q <= S_QWAIT;
				S_QWAIT: begin
					if (q_rdata[8:0] >= eff_w || q_rdata[17:9] >= eff_h)
						state_q <= (count_q == '0) ? S_IDLE : S_POP;
					else state_q <= S_CTR;
				end
				S_CTR:   state_q <= S_CWAIT;
				S_CWAIT: begin
					k_q <= 4'd0;
					state_q <= S_NB;
				end
				S_NB:    state_q <= S_NWAIT;
				S_NWAIT: state_q <= S_NCHK;
				S_NCHK: begin
					if (k_q == 4'd7) state_q <= (count_q == '0 && !q_we) ? S_IDLE : S_POP;
					else begin
						k_q <= k_q + 4'd1;
						state_q <= S_NB;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_QWAIT) begin
			x_q <= q_rdata[8:0];
			y_q <= q_rdata[17:9];
		end
		if (state_q == S_CWAIT) nv_q <= g_rdata + 16'd1;
		if (state_q == S_NB) begin
			nx_q <= nx;
			ny_q <= ny;
		end
	end

	tgbg_ram #(.WIDTH(16), .DEPTH(CELLS)) u_grid (
		.clk(clk), .we(g_we), .addr(g_addr), .wdata(g_wdata), .rdata(g_rdata)
	);
	tgbg_ram #(.WIDTH(18), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wdata), .rdata(q_rdata)
	);

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= QC'(QUEUE_DEPTH))
		else $error("position queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> pop)
		else $error("result without retiring its request");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> count_q != '0)
		else $error("pop from empty position queue");
endmodule
`default_nettype wire

/* sv/toroidal_grid_bfs_gradient_top.sv */
// ----------------------------------------------------------------------------
// toroidal_grid_bfs_gradient_top: breadth-first distance field on a torus
// Command interface with a grid memory and a first-in first-out seed queue.
// ----------------------------------------------------------------------------
// Usage: a request is taken at a rising edge where start is high and busy is
// low. The request carries opcode, pos_x, pos_y and cell_value. Every request
// produces exactly one result, shown on read_value and status for a single
// cycle while done is high; the receiver cannot stall it.
// Sequence: a run pops each queued position and handles it in order: a queue
// read, a center read, then eight read and check steps through the single
// grid port. A popped position outside the current sizes is dropped after
// its queue read.
// A two-entry request queue sits between the intake and the engine, so a
// second request can be taken while the first executes; busy rises when it
// is full.
// Configuration: cfg_we, cfg_index and cfg_data write grid_width (index 0) or
// grid_height (index 1); write only while no request is outstanding.
// Reset: the queue pointers clear and both sizes return to 64. The grid
// and queue memories are not cleared, so every cell must be written first.
// ----------------------------------------------------------------------------
`default_nettype none
module toroidal_grid_bfs_gradient_top import tgbg_pkg::*; #(
	parameter int MAX_WIDTH   = 64,
	parameter int MAX_HEIGHT  = 64,
	parameter int QUEUE_DEPTH = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [5:0]  pos_x,
	input  wire logic [5:0]  pos_y,
	input  wire logic [15:0] cell_value,
	output logic             done,
	output logic [15:0]      read_value,
	output logic [1:0]       status,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_data
);
	// Hand-off signals between the intake and the engine.
	logic       accept, fifo_valid, pop;
	tgbg_req_t  fifo_head;
	logic [8:0] eff_w, eff_h;
	logic       done_c;
	logic [15:0] rv_c;
	logic [1:0]  st_c;

	tgbg_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.pos_x(pos_x), .pos_y(pos_y), .cell_value(cell_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pop(pop), .accept(accept), .fifo_valid(fifo_valid),
		.fifo_head(fifo_head), .eff_w(eff_w), .eff_h(eff_h), .busy_out(busy)
	);

	tgbg_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
		.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .fifo_valid(fifo_valid),
		.fifo_head(fifo_head), .eff_w(eff_w), .eff_h(eff_h), .pop(pop),
		.done(done_c), .read_value(rv_c), .status(st_c)
	);

	// The result is registered so the outputs come straight from flops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= done_c;
		end
	end

	always_ff @(posedge clk) begin
		read_value <= rv_c;
		status     <= st_c;
	end

	assert property (@(posedge clk) disable iff (!arst_n) accept |-> !busy)
		else $error("request taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> status != 2'd3)
		else $error("undefined status code");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> read_value == 16'd0)
		else $error("error result carries data");
endmodule
`default_nettype wire
